/* rtl/core/pij_pkg.sv */
// Shared types, constants and tables for the pose increment Jacobian block.
package pij_pkg;

    // Fixed-point constants, Q12.20 unless noted.
    localparam int Q20_TWO_PI   = 6588397;
    localparam int Q20_PI       = 3294199;
    localparam int Q20_HALF_PI  = 1647099;
    localparam int Q20_HALF     = 524288;
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_GAIN  = 652032874;     // Q30
    localparam int REDUCE_STEPS = 9;             // quotient bits of |angle| / 2pi
    localparam int TRIG_W       = 24;            // width of sine, cosine and their products
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Action codes of an input transaction.
    typedef enum logic [1:0] {
        ACT_LOAD_ROT  = 2'd0,
        ACT_LOAD_POSE = 2'd1,
        ACT_COMPUTE   = 2'd2
    } t_action;

    localparam logic [1:0] ROW_INVALID = 2'd3;

    // Classified work handed from the front to the back.
    typedef enum logic [1:0] {
        KIND_LOAD_ROT,
        KIND_LOAD_POSE,
        KIND_COMPUTE
    } t_kind;

    typedef struct packed {
        logic [1:0]         action;
        logic [1:0]         row_select;
        logic signed [31:0] value_a;
        logic signed [31:0] value_b;
        logic signed [31:0] value_c;
        logic signed [31:0] value_d;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         jacobian_row;
        logic signed [31:0] d_phi;
        logic signed [31:0] d_psi;
        logic signed [31:0] d_theta;
        logic signed [31:0] d_x;
        logic signed [31:0] d_y;
        logic signed [31:0] d_z;
        logic               last_row;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        t_kind              kind;
        logic [1:0]         row;
        logic signed [31:0] value_a;
        logic signed [31:0] value_b;
        logic signed [31:0] value_c;
        logic signed [31:0] value_d;
    } t_queue_item;

    typedef struct packed {
        logic signed [31:0] c0;
        logic signed [31:0] c1;
        logic signed [31:0] c2;
    } t_rot_row;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_REDUCE,
        CS_FOLD,
        CS_ROTATE,
        CS_FINISH
    } t_cordic_state;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_CORDIC,
        BS_TRIG,
        BS_DOT_MUL,
        BS_DOT_ADD,
        BS_OUT_MUL,
        BS_OUT_ADD,
        BS_EMIT
    } t_back_state;

    // Arctangent of 2^-i in Q30.
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            5'd24: v = 30'd64;
            5'd25: v = 30'd32;
            5'd26: v = 30'd16;
            5'd27: v = 30'd8;
            5'd28: v = 30'd4;
            5'd29: v = 30'd2;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/pose_increment_jacobian_block_unit.sv */
// Top level of the pose increment Jacobian block: front queue and compute back end.
//
// Usage: transactions enter on the input channel (valid/ready). Action 0 loads a row
// of the first pose's rotation, action 1 loads a row of the second pose's 3x4 matrix,
// action 2 computes with three angles. Loads give no output and drop row three;
// action 3 is dropped. A compute produces twelve result transactions, one per entry
// of the relative pose, in row-major order; last_row marks the twelfth.
// A load is absorbed once it reaches the back end, which stays idle. A compute runs
// the three parallel CORDIC units (range reduction, fold, 30 rotations), then the trig
// products on one shared multiplier, then per rotation row the inner sums and, for
// each emitted result, the outer sums.
// A short queue decouples the input from the back end, so loads and the next compute
// are taken while a compute is running until the queue fills.
// Reset (synchronous, active low) empties the queue and returns the sequencer to idle;
// the matrix stores hold no defined value until loaded.
// A stalled receiver holds the registered result; the back end waits until it is taken.
module pose_increment_jacobian_block_unit
    import pij_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic        w_q_valid, w_q_pop;
    t_queue_item w_q_item;

    pij_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk, .i_rst_n,
        .i_in_valid, .o_in_ready, .i_in_item,
        .o_q_valid(w_q_valid), .o_q_item(w_q_item), .i_q_pop(w_q_pop)
    );

    pij_back u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(w_q_valid), .i_q_item(w_q_item), .o_q_pop(w_q_pop),
        .o_out_valid, .i_out_ready, .o_out_item
    );

endmodule

/* rtl/core/pij_front.sv */
// Front end: accepts input transactions, drops ignored ones and queues the rest.
module pij_front
    import pij_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_q_valid,
    output t_queue_item o_q_item,
    input  logic        i_q_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_queue_item r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_keep, w_push, w_pop;
    t_kind            w_kind;

    // Classify the incoming transaction; loads of row three and unknown actions are dropped.
    always_comb begin
        w_keep = 1'b0;
        w_kind = KIND_COMPUTE;
        unique case (i_in_item.action)
            ACT_LOAD_ROT: begin
                w_kind = KIND_LOAD_ROT;
                w_keep = (i_in_item.row_select != ROW_INVALID);
            end
            ACT_LOAD_POSE: begin
                w_kind = KIND_LOAD_POSE;
                w_keep = (i_in_item.row_select != ROW_INVALID);
            end
            ACT_COMPUTE: begin
                w_kind = KIND_COMPUTE;
                w_keep = 1'b1;
            end
            default: begin
                w_kind = KIND_COMPUTE;
                w_keep = 1'b0;
            end
        endcase
    end

    assign o_in_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign w_push     = i_in_valid && o_in_ready && w_keep;
    assign o_q_valid  = (r_count != '0);
    assign w_pop      = o_q_valid && i_q_pop;
    assign o_q_item   = r_mem[r_rd_ptr];

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= '{kind: w_kind, row: i_in_item.row_select,
                                 value_a: i_in_item.value_a, value_b: i_in_item.value_b,
                                 value_c: i_in_item.value_c, value_d: i_in_item.value_d};
        end
    end

endmodule

/* rtl/core/pij_cordic.sv */
// Iterative sine and cosine unit: range reduction by 2pi, quadrant fold, 30 CORDIC steps.
module pij_cordic
    import pij_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [31:0]       i_angle,
    output logic                     o_done,
    output logic signed [TRIG_W-1:0] o_sin,
    output logic signed [TRIG_W-1:0] o_cos
);

    localparam logic signed [24:0] TWO_PI_S  = 25'(Q20_TWO_PI);
    localparam logic signed [24:0] PI_S      = 25'(Q20_PI);
    localparam logic signed [24:0] HALF_PI_S = 25'(Q20_HALF_PI);

    t_cordic_state r_state, n_state;
    logic [3:0]         r_red;
    logic [4:0]         r_it;
    logic [31:0]        r_m;
    logic               r_ang_neg, r_flip, r_done;
    logic signed [32:0] r_x, r_y, r_z;
    logic signed [TRIG_W-1:0] r_sin, r_cos;

    logic [31:0]        w_sub;
    logic signed [24:0] w_m, w_r0, w_r1, w_r2;
    logic               w_flip;
    logic signed [32:0] w_dx, w_dy, w_at, w_cx, w_sy;
    logic signed [TRIG_W-1:0] w_cos, w_sin;

    // Restoring reduction: subtract 2pi shifted by the current quotient bit.
    assign w_sub = 32'(Q20_TWO_PI) << r_red;

    // Fold the remainder into (-pi, pi], then into [-pi/2, pi/2] with a sign flag.
    always_comb begin
        w_m  = signed'({2'b00, r_m[22:0]});
        w_r0 = (r_ang_neg && (r_m[22:0] != '0)) ? TWO_PI_S - w_m : w_m;
        w_r1 = (w_r0 > PI_S) ? w_r0 - TWO_PI_S : w_r0;
        w_flip = 1'b0;
        w_r2 = w_r1;
        if (w_r1 > HALF_PI_S) begin
            w_r2   = w_r1 - PI_S;
            w_flip = 1'b1;
        end else if (w_r1 < -HALF_PI_S) begin
            w_r2   = w_r1 + PI_S;
            w_flip = 1'b1;
        end
    end

    // One rotation step.
    assign w_dx = r_y >>> r_it;
    assign w_dy = r_x >>> r_it;
    assign w_at = signed'({3'b000, atan_q30(r_it)});

    // Round Q30 to Q20 and undo the quadrant fold.
    assign w_cx  = r_x + 33'sd512;
    assign w_sy  = r_y + 33'sd512;
    assign w_cos = TRIG_W'(signed'(w_cx[32:10]));
    assign w_sin = TRIG_W'(signed'(w_sy[32:10]));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CS_IDLE:   if (i_start) n_state = CS_REDUCE;
            CS_REDUCE: if (r_red == '0) n_state = CS_FOLD;
            CS_FOLD:   n_state = CS_ROTATE;
            CS_ROTATE: if (r_it == 5'(CORDIC_STEPS - 1)) n_state = CS_FINISH;
            CS_FINISH: n_state = CS_IDLE;
            default:   n_state = CS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_done  <= 1'b0;
            r_red   <= '0;
            r_it    <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == CS_FINISH);
            if (r_state == CS_IDLE) begin
                r_red <= 4'(REDUCE_STEPS - 1);
            end else if (r_state == CS_REDUCE) begin
                r_red <= r_red - 1'b1;
            end
            if (r_state == CS_ROTATE) begin
                r_it <= r_it + 1'b1;
            end else begin
                r_it <= '0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            CS_IDLE: begin
                if (i_start) begin
                    r_ang_neg <= i_angle[31];
                    r_m <= i_angle[31] ? (~unsigned'(i_angle) + 32'd1) : unsigned'(i_angle);
                end
            end
            CS_REDUCE: begin
                if (r_m >= w_sub) begin
                    r_m <= r_m - w_sub;
                end
            end
            CS_FOLD: begin
                r_flip <= w_flip;
                r_x    <= 33'(CORDIC_GAIN);
                r_y    <= '0;
                r_z    <= 33'(w_r2) <<< 10;
            end
            CS_ROTATE: begin
                if (!r_z[32]) begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - w_at;
                end else begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + w_at;
                end
            end
            CS_FINISH: begin
                r_cos <= r_flip ? -w_cos : w_cos;
                r_sin <= r_flip ? -w_sin : w_sin;
            end
            default: begin
                r_m <= r_m;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_sin  = r_sin;
    assign o_cos  = r_cos;

endmodule

/* rtl/core/pij_back.sv */
// Back end: holds the pose matrices and sequences the Jacobian computation row by row.
module pij_back
    import pij_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_queue_item i_q_item,
    output logic        o_q_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item
);

    // Slots of the trig product table.
    localparam int TP_SFSS = 0, TP_CFCS = 1, TP_A2 = 2, TP_CFSS = 3, TP_CSSF = 4;
    localparam int TP_B2 = 5, TP_C2 = 6, TP_D2 = 7, TP_E = 8, TP_F = 9, TP_G = 10;
    localparam int TP_H = 11, TP_I = 12, TP_J = 13, TP_K = 14, TP_L = 15, TP_M = 16;
    localparam int TP_N = 17, TP_O = 18, TP_Q = 19, TP_COUNT = 20;

    t_back_state r_state, n_state;
    logic [4:0] r_step, n_step;
    logic [1:0] r_row, n_row, r_col, n_col, r_der, n_der;
    logic [2:0] r_dot, n_dot;
    logic       r_out_valid, w_load_out, w_start, w_pop, w_trig_write, w_combine;

    t_rot_row           r_rot [3];
    logic signed [31:0] r_pose0 [4];
    logic signed [31:0] r_pose1 [4];
    logic signed [31:0] r_pose2 [4];
    logic signed [TRIG_W-1:0] r_tp [TP_COUNT];
    logic signed [TRIG_W-1:0] r_ca, r_cb, r_cc, r_cd;
    logic signed [55:0] r_prod [3];
    logic signed [37:0] r_p [8];
    logic signed [49:0] r_hi [3];
    logic signed [52:0] r_lo [3];
    logic signed [31:0] r_dv [3];
    logic               r_sat;
    t_out_item          r_out;

    logic               w_done;
    logic signed [TRIG_W-1:0] sf, cf, ss, cs, st, ct;
    logic signed [TRIG_W-1:0] w_op_a, w_op_b, w_trig;
    logic signed [47:0] w_tmul;
    t_rot_row           w_rr;
    logic signed [TRIG_W-1:0] w_k0, w_k1, w_k2;
    logic signed [57:0] w_dsum;
    logic signed [37:0] w_psel [3];
    logic signed [31:0] w_v [3];
    logic signed [51:0] w_hsum;
    logic signed [54:0] w_lsum;
    logic signed [52:0] w_res;
    logic               w_over;
    logic signed [31:0] w_clip;

    // Three sine and cosine units, one per angle.
    pij_cordic u_cordic_phi (
        .i_clk, .i_rst_n, .i_start(w_start), .i_angle(i_q_item.value_a),
        .o_done(w_done), .o_sin(sf), .o_cos(cf)
    );
    pij_cordic u_cordic_psi (
        .i_clk, .i_rst_n, .i_start(w_start), .i_angle(i_q_item.value_b),
        .o_done(), .o_sin(ss), .o_cos(cs)
    );
    pij_cordic u_cordic_theta (
        .i_clk, .i_rst_n, .i_start(w_start), .i_angle(i_q_item.value_c),
        .o_done(), .o_sin(st), .o_cos(ct)
    );

    // Trig products: one rounded Q20 multiply per step.
    always_comb begin
        w_op_a = sf;
        w_op_b = ss;
        case (r_step)
            5'd0:  begin w_op_a = sf;             w_op_b = ss; end
            5'd1:  begin w_op_a = cf;             w_op_b = cs; end
            5'd2:  begin w_op_a = r_tp[TP_CFCS];  w_op_b = st; end
            5'd3:  begin w_op_a = cf;             w_op_b = ss; end
            5'd4:  begin w_op_a = cs;             w_op_b = sf; end
            5'd5:  begin w_op_a = r_tp[TP_CSSF];  w_op_b = st; end
            5'd6:  begin w_op_a = r_tp[TP_CFSS];  w_op_b = st; end
            5'd7:  begin w_op_a = r_tp[TP_SFSS];  w_op_b = st; end
            5'd8:  begin w_op_a = cf;             w_op_b = ct; end
            5'd9:  begin w_op_a = ct;             w_op_b = sf; end
            5'd10: begin w_op_a = cs;             w_op_b = ct; end
            5'd11: begin w_op_a = ct;             w_op_b = ss; end
            5'd12: begin w_op_a = ss;             w_op_b = st; end
            5'd13: begin w_op_a = r_tp[TP_E];     w_op_b = ss; end
            5'd14: begin w_op_a = r_tp[TP_F];     w_op_b = ss; end
            5'd15: begin w_op_a = cf;             w_op_b = st; end
            5'd16: begin w_op_a = sf;             w_op_b = st; end
            5'd17: begin w_op_a = cs;             w_op_b = st; end
            5'd18: begin w_op_a = r_tp[TP_E];     w_op_b = cs; end
            5'd19: begin w_op_a = r_tp[TP_F];     w_op_b = cs; end
            default: begin w_op_a = sf;           w_op_b = ss; end
        endcase
    end

    assign w_tmul = 48'(w_op_a) * 48'(w_op_b) + 48'(Q20_HALF);
    assign w_trig = w_tmul[43:20];

    // Coefficients of the eight inner dot products for the current rotation row.
    assign w_rr = r_rot[r_row];

    always_comb begin
        w_k0 = '0;
        w_k1 = '0;
        w_k2 = '0;
        case (r_dot)
            3'd0: begin w_k0 = '0;           w_k1 = -r_ca;        w_k2 = r_cb;         end
            3'd1: begin w_k0 = '0;           w_k1 = -r_cc;        w_k2 = r_cd;         end
            3'd2: begin w_k0 = '0;           w_k1 = -r_tp[TP_E];  w_k2 = -r_tp[TP_F];  end
            3'd3: begin w_k0 = -r_tp[TP_H];  w_k1 = r_cd;         w_k2 = r_cc;         end
            3'd4: begin w_k0 = -r_tp[TP_G];  w_k1 = -r_cb;        w_k2 = -r_ca;        end
            3'd5: begin w_k0 = -r_tp[TP_N];  w_k1 = r_tp[TP_Q];   w_k2 = -r_tp[TP_O];  end
            3'd6: begin w_k0 = r_tp[TP_I];   w_k1 = -r_tp[TP_K];  w_k2 = r_tp[TP_J];   end
            3'd7: begin w_k0 = ct;           w_k1 = r_tp[TP_M];   w_k2 = -r_tp[TP_L];  end
            default: begin w_k0 = '0;        w_k1 = '0;           w_k2 = '0;           end
        endcase
    end

    assign w_dsum = 58'(r_prod[0]) + 58'(r_prod[1]) + 58'(r_prod[2]) + 58'(Q20_HALF);

    // Inner sums and pose column feeding the current derivative.
    always_comb begin
        case (r_der)
            2'd0: begin w_psel[0] = r_p[0]; w_psel[1] = r_p[1]; w_psel[2] = r_p[2]; end
            2'd1: begin w_psel[0] = r_p[3]; w_psel[1] = r_p[4]; w_psel[2] = '0;     end
            default: begin w_psel[0] = r_p[5]; w_psel[1] = r_p[6]; w_psel[2] = r_p[7]; end
        endcase
        w_v[0] = r_pose0[r_col];
        w_v[1] = r_pose1[r_col];
        w_v[2] = r_pose2[r_col];
    end

    // Exact outer sum rounded to Q20, then clipped to 32 bits.
    assign w_hsum = 52'(r_hi[0]) + 52'(r_hi[1]) + 52'(r_hi[2]);
    assign w_lsum = 55'(r_lo[0]) + 55'(r_lo[1]) + 55'(r_lo[2]) + 55'(Q20_HALF);
    assign w_res  = 53'(w_hsum) + 53'(signed'(w_lsum[54:20]));
    assign w_over = (w_res[52:31] != {22{w_res[31]}});
    assign w_clip = w_res[52] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;

    // Sequencer: next state, counters and handshakes.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_row   = r_row;
        n_col   = r_col;
        n_der   = r_der;
        n_dot   = r_dot;
        w_pop   = 1'b0;
        w_start = 1'b0;
        w_load_out   = 1'b0;
        w_trig_write = 1'b0;
        w_combine    = 1'b0;
        unique case (r_state)
            BS_IDLE: begin
                if (i_q_valid) begin
                    w_pop = 1'b1;
                    if (i_q_item.kind == KIND_COMPUTE) begin
                        w_start = 1'b1;
                        n_state = BS_CORDIC;
                    end
                end
            end
            BS_CORDIC: begin
                n_step = '0;
                if (w_done) n_state = BS_TRIG;
            end
            BS_TRIG: begin
                if (r_step == 5'(TP_COUNT)) begin
                    w_combine = 1'b1;
                    n_row   = '0;
                    n_dot   = '0;
                    n_state = BS_DOT_MUL;
                end else begin
                    w_trig_write = 1'b1;
                    n_step = r_step + 1'b1;
                end
            end
            BS_DOT_MUL: n_state = BS_DOT_ADD;
            BS_DOT_ADD: begin
                n_dot = r_dot + 1'b1;
                if (r_dot == 3'd7) begin
                    n_col   = '0;
                    n_der   = '0;
                    n_state = BS_OUT_MUL;
                end else begin
                    n_state = BS_DOT_MUL;
                end
            end
            BS_OUT_MUL: n_state = BS_OUT_ADD;
            BS_OUT_ADD: begin
                if (r_der == 2'd2) begin
                    n_state = BS_EMIT;
                end else begin
                    n_der   = r_der + 1'b1;
                    n_state = BS_OUT_MUL;
                end
            end
            BS_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load_out = 1'b1;
                    n_der = '0;
                    if (r_col == 2'd3) begin
                        if (r_row == 2'd2) begin
                            n_state = BS_IDLE;
                        end else begin
                            n_row   = r_row + 1'b1;
                            n_dot   = '0;
                            n_state = BS_DOT_MUL;
                        end
                    end else begin
                        n_col   = r_col + 1'b1;
                        n_state = BS_OUT_MUL;
                    end
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_step      <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_der       <= '0;
            r_dot       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_row   <= n_row;
            r_col   <= n_col;
            r_der   <= n_der;
            r_dot   <= n_dot;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Matrix stores, written by load transactions.
    always_ff @(posedge i_clk) begin
        if (w_pop && i_q_item.kind == KIND_LOAD_ROT) begin
            r_rot[i_q_item.row] <= '{c0: i_q_item.value_a, c1: i_q_item.value_b,
                                     c2: i_q_item.value_c};
        end
        if (w_pop && i_q_item.kind == KIND_LOAD_POSE) begin
            case (i_q_item.row)
                2'd0: begin
                    r_pose0[0] <= i_q_item.value_a; r_pose0[1] <= i_q_item.value_b;
                    r_pose0[2] <= i_q_item.value_c; r_pose0[3] <= i_q_item.value_d;
                end
                2'd1: begin
                    r_pose1[0] <= i_q_item.value_a; r_pose1[1] <= i_q_item.value_b;
                    r_pose1[2] <= i_q_item.value_c; r_pose1[3] <= i_q_item.value_d;
                end
                default: begin
                    r_pose2[0] <= i_q_item.value_a; r_pose2[1] <= i_q_item.value_b;
                    r_pose2[2] <= i_q_item.value_c; r_pose2[3] <= i_q_item.value_d;
                end
            endcase
        end
    end

    // Arithmetic datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_trig_write) begin
            r_tp[r_step] <= w_trig;
        end
        if (w_combine) begin
            r_ca <= r_tp[TP_SFSS] - r_tp[TP_A2];
            r_cb <= r_tp[TP_CFSS] + r_tp[TP_B2];
            r_cc <= r_tp[TP_CSSF] + r_tp[TP_C2];
            r_cd <= r_tp[TP_CFCS] - r_tp[TP_D2];
        end
        if (r_state == BS_DOT_MUL) begin
            r_prod[0] <= 56'(w_rr.c0) * 56'(w_k0);
            r_prod[1] <= 56'(w_rr.c1) * 56'(w_k1);
            r_prod[2] <= 56'(w_rr.c2) * 56'(w_k2);
        end
        if (r_state == BS_DOT_ADD) begin
            r_p[r_dot] <= w_dsum[57:20];
        end
        if (r_state == BS_OUT_MUL) begin
            for (int j = 0; j < 3; j++) begin
                r_hi[j] <= 50'(w_v[j]) * 50'(signed'(w_psel[j][37:20]));
                r_lo[j] <= 53'(w_v[j]) * 53'(signed'({1'b0, w_psel[j][19:0]}));
            end
        end
        if (r_state == BS_OUT_ADD) begin
            r_dv[r_der] <= w_over ? w_clip : w_res[31:0];
            r_sat       <= ((r_der == 2'd0) ? 1'b0 : r_sat) | w_over;
        end
        if (w_load_out) begin
            r_out.jacobian_row <= {r_row, r_col};
            r_out.d_phi        <= r_dv[0];
            r_out.d_psi        <= r_dv[1];
            r_out.d_theta      <= r_dv[2];
            r_out.d_x          <= (r_col == 2'd3) ? w_rr.c0 : '0;
            r_out.d_y          <= (r_col == 2'd3) ? w_rr.c1 : '0;
            r_out.d_z          <= (r_col == 2'd3) ? w_rr.c2 : '0;
            r_out.last_row     <= (r_col == 2'd3) && (r_row == 2'd2);
            r_out.saturated    <= r_sat;
        end
    end

    assign o_q_pop     = w_pop;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

/* tb/tb_pose_increment_jacobian_block_unit.sv */
// Self-checking testbench for the pose increment Jacobian block unit.
module tb_pose_increment_jacobian_block_unit;
    import pij_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 80;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Predicts Jacobian rows from loaded poses and checks the block's result transactions.
    class jacobian_scoreboard;
        longint rot_store[9];
        longint pose_store[12];
        t_out_item pending_rows[$];
        int errors;
        longint atan_tab[30] = '{
            843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
            16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
            65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
            16, 8, 4, 2};

        function new();
            errors = 0;
            foreach (rot_store[j]) rot_store[j] = 0;
            foreach (pose_store[j]) pose_store[j] = 0;
        endfunction

        function longint round_q20(longint v);
            return (v + Q20_HALF) >>> 20;
        endfunction

        function longint mul_q20(longint a, longint b);
            return round_q20(a * b);
        endfunction

        // Range reduction, quadrant fold and CORDIC rotation in Q30.
        function void angle_trig(longint ang, output longint s, output longint c);
            longint r, x, y, z, dx, dy;
            bit flip;
            r = ang % Q20_TWO_PI;
            flip = 0;
            x = CORDIC_GAIN;
            y = 0;
            if (r < 0) r += Q20_TWO_PI;
            if (r > Q20_PI) r -= Q20_TWO_PI;
            if (r > Q20_HALF_PI) begin
                r -= Q20_PI;
                flip = 1;
            end else if (r < -Q20_HALF_PI) begin
                r += Q20_PI;
                flip = 1;
            end
            z = r * 1024;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= atan_tab[i];
                end else begin
                    x += dx; y -= dy; z += atan_tab[i];
                end
            end
            c = (x + 512) >>> 10;
            s = (y + 512) >>> 10;
            if (flip) begin
                c = -c;
                s = -s;
            end
        endfunction

        // Exact sum of pose entries times inner sums, rounded, then clipped to 32 bits.
        function longint pose_sum(longint v0, longint v1, longint v2,
                                  longint p0, longint p1, longint p2, inout bit clip);
            longint hi, lo, ph, r;
            longint v[3], p[3];
            v = '{v0, v1, v2};
            p = '{p0, p1, p2};
            hi = 0;
            lo = 0;
            for (int j = 0; j < 3; j++) begin
                ph = p[j] >>> 20;
                hi += v[j] * ph;
                lo += v[j] * (p[j] - ph * 1048576);
            end
            r = hi + round_q20(lo);
            if (r > 64'sd2147483647) begin
                clip = 1;
                return 64'sd2147483647;
            end
            if (r < -64'sd2147483648) begin
                clip = 1;
                return -64'sd2147483648;
            end
            return r;
        endfunction

        // Notes an accepted input transaction and queues the rows it causes.
        function void note_input(t_in_item it);
            longint sf, cf, ss, cs, st, ct;
            longint ta, tb, tc, td, te, tf, tg, th, ti, tj, tk, tl, tm, tn, to_, tq;
            longint a, b, c, v0, v1, v2, dphi, dpsi, dth;
            bit clip;
            t_out_item row;
            if (it.action == ACT_LOAD_ROT || it.action == ACT_LOAD_POSE) begin
                if (it.row_select == ROW_INVALID) return;
                if (it.action == ACT_LOAD_ROT) begin
                    rot_store[it.row_select * 3 + 0] = it.value_a;
                    rot_store[it.row_select * 3 + 1] = it.value_b;
                    rot_store[it.row_select * 3 + 2] = it.value_c;
                end else begin
                    pose_store[it.row_select * 4 + 0] = it.value_a;
                    pose_store[it.row_select * 4 + 1] = it.value_b;
                    pose_store[it.row_select * 4 + 2] = it.value_c;
                    pose_store[it.row_select * 4 + 3] = it.value_d;
                end
                return;
            end
            if (it.action != ACT_COMPUTE) return;
            angle_trig(it.value_a, sf, cf);
            angle_trig(it.value_b, ss, cs);
            angle_trig(it.value_c, st, ct);
            ta = mul_q20(sf, ss) - mul_q20(mul_q20(cf, cs), st);
            tb = mul_q20(cf, ss) + mul_q20(mul_q20(cs, sf), st);
            tc = mul_q20(cs, sf) + mul_q20(mul_q20(cf, ss), st);
            td = mul_q20(cf, cs) - mul_q20(mul_q20(sf, ss), st);
            te = mul_q20(cf, ct);
            tf = mul_q20(ct, sf);
            tg = mul_q20(cs, ct);
            th = mul_q20(ct, ss);
            ti = mul_q20(ss, st);
            tj = mul_q20(te, ss);
            tk = mul_q20(tf, ss);
            tl = mul_q20(cf, st);
            tm = mul_q20(sf, st);
            tn = mul_q20(cs, st);
            to_ = mul_q20(te, cs);
            tq = mul_q20(tf, cs);
            for (int n = 0; n < 12; n++) begin
                a = rot_store[(n / 4) * 3 + 0];
                b = rot_store[(n / 4) * 3 + 1];
                c = rot_store[(n / 4) * 3 + 2];
                v0 = pose_store[n % 4];
                v1 = pose_store[4 + n % 4];
                v2 = pose_store[8 + n % 4];
                clip = 0;
                dphi = pose_sum(v0, v1, v2, round_q20(c * tb - b * ta),
                                round_q20(c * td - b * tc), round_q20(-b * te - c * tf), clip);
                dpsi = pose_sum(v0, v1, v2, round_q20(b * td + c * tc - a * th),
                                round_q20(-b * tb - c * ta - a * tg), 0, clip);
                dth = pose_sum(v0, v1, v2, round_q20(-a * tn - c * to_ + b * tq),
                               round_q20(a * ti + c * tj - b * tk),
                               round_q20(a * ct - c * tl + b * tm), clip);
                row.jacobian_row = 4'(n);
                row.d_phi = dphi[31:0];
                row.d_psi = dpsi[31:0];
                row.d_theta = dth[31:0];
                row.d_x = (n % 4 == 3) ? a[31:0] : 32'd0;
                row.d_y = (n % 4 == 3) ? b[31:0] : 32'd0;
                row.d_z = (n % 4 == 3) ? c[31:0] : 32'd0;
                row.last_row = (n == 11);
                row.saturated = clip;
                pending_rows.push_back(row);
            end
        endfunction

        // Compares one result transaction with the oldest expected row.
        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_rows.size() == 0) begin
                errors++;
                $display("%0t: unexpected result row, actual %h", $realtime, got);
                return;
            end
            want = pending_rows.pop_front();
            if (got.jacobian_row !== want.jacobian_row || got.d_phi !== want.d_phi ||
                got.d_psi !== want.d_psi || got.d_theta !== want.d_theta ||
                got.d_x !== want.d_x || got.d_y !== want.d_y || got.d_z !== want.d_z ||
                got.last_row !== want.last_row || got.saturated !== want.saturated) begin
                errors++;
                $display("%0t: row %0d expected phi %h psi %h th %h x %h y %h z %h l %b s %b",
                         $realtime, want.jacobian_row, want.d_phi, want.d_psi, want.d_theta,
                         want.d_x, want.d_y, want.d_z, want.last_row, want.saturated);
                $display("%0t: row %0d actual   phi %h psi %h th %h x %h y %h z %h l %b s %b",
                         $realtime, got.jacobian_row, got.d_phi, got.d_psi, got.d_theta,
                         got.d_x, got.d_y, got.d_z, got.last_row, got.saturated);
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    jacobian_scoreboard jac_board;
    int send_idle_pct;
    int recv_stall_pct;
    int cycle_count;

    pose_increment_jacobian_block_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Receiver back-pressure, set by the current idling phase.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) jac_board.check_result(o_out_item);
    end

    // Run watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Presents one transaction, with random idle gaps, and waits for its acceptance.
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (!o_in_ready);
        jac_board.note_input(it);
    endtask

    task automatic send_fields(input logic [1:0] act, input logic [1:0] row,
                               input int va, input int vb, input int vc, input int vd);
        t_in_item it;
        it.action = act;
        it.row_select = row;
        it.value_a = va;
        it.value_b = vb;
        it.value_c = vc;
        it.value_d = vd;
        send_item(it);
    endtask

    // Mostly moderate Q20 values within +-4, sometimes any 32-bit pattern.
    function automatic int pick_value();
        if ($urandom_range(99) < 20) return $urandom;
        return int'($urandom_range(8 << 20)) - (4 << 20);
    endfunction

    initial begin
        int counted;
        int sel;
        jac_board = new();
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_out_ready = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extreme stores and angles, ignored rows and actions.
        send_fields(ACT_LOAD_ROT, 2'd0, 32'h7FFFFFFF, 32'h80000000, 0, 32'h7FFFFFFF);
        send_fields(ACT_LOAD_ROT, 2'd1, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 0);
        send_fields(ACT_LOAD_ROT, 2'd2, 1 << 20, 0, -(1 << 20), 32'h80000000);
        send_fields(ACT_LOAD_POSE, 2'd0, 32'h7FFFFFFF, 32'h80000000, 1, -1);
        send_fields(ACT_LOAD_POSE, 2'd1, 0, 1 << 20, 32'h7FFFFFFF, 32'h80000000);
        send_fields(ACT_LOAD_POSE, 2'd2, -(1 << 20), 32'h80000000, 0, 32'h7FFFFFFF);
        send_fields(ACT_COMPUTE, 2'd0, 0, 0, 0, 0);
        send_fields(ACT_COMPUTE, 2'd3, 32'h7FFFFFFF, 32'h80000000, Q20_PI, 32'hFFFFFFFF);
        send_fields(ACT_LOAD_ROT, ROW_INVALID, 1, 2, 3, 4);
        send_fields(ACT_LOAD_POSE, ROW_INVALID, 5, 6, 7, 8);
        send_fields(ACT_UNUSED, 2'd1, 9, 10, 11, 12);
        // Identity-like poses so the quadrant fold and the reduction show clearly.
        send_fields(ACT_LOAD_ROT, 2'd0, 1 << 20, 0, 0, 0);
        send_fields(ACT_LOAD_ROT, 2'd1, 0, 1 << 20, 0, 0);
        send_fields(ACT_LOAD_ROT, 2'd2, 0, 0, 1 << 20, 0);
        send_fields(ACT_LOAD_POSE, 2'd0, 1 << 20, 0, 0, 3 << 20);
        send_fields(ACT_LOAD_POSE, 2'd1, 0, 1 << 20, 0, -(2 << 20));
        send_fields(ACT_LOAD_POSE, 2'd2, 0, 0, 1 << 20, 1 << 19);
        send_fields(ACT_COMPUTE, 2'd0, Q20_HALF_PI, Q20_HALF_PI + 1, -Q20_HALF_PI - 1, 0);
        send_fields(ACT_COMPUTE, 2'd1, Q20_PI, -Q20_PI, Q20_PI + 1, 0);
        send_fields(ACT_COMPUTE, 2'd2, Q20_TWO_PI, -Q20_TWO_PI, 32'h80000000, 0);
        send_fields(ACT_COMPUTE, 2'd0, 32'h7FFFFFFF, 32'hFFFFFFFF, 1, 0);

        // Random: mostly loads and computes with random content, some ignored noise.
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            case (counted * 4 / RANDOM_ITEMS)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            sel = $urandom_range(99);
            if (sel < 8) begin
                send_fields(ACT_UNUSED, 2'($urandom), $urandom, $urandom, $urandom,
                            $urandom);
            end else if (sel < 14) begin
                send_fields(2'($urandom_range(1)), ROW_INVALID, $urandom, $urandom,
                            $urandom, $urandom);
            end else if (sel < 68) begin
                send_fields(2'($urandom_range(1)), 2'($urandom_range(2)), pick_value(),
                            pick_value(), pick_value(), pick_value());
                counted++;
            end else begin
                send_fields(ACT_COMPUTE, 2'($urandom), pick_value(), pick_value(),
                            pick_value(), $urandom);
                counted++;
            end
        end
        i_in_valid <= 1'b0;

        // Drain, then let the block settle.
        while (jac_board.pending_rows.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (jac_board.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
